// ----- rtl/pud_pkg.sv -----
// Shared types, constants and helpers for the particle update and depth sort block.
package pud_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LIM_W    = 7;
    localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int IN_W     = 312;
    localparam int OUT_W    = 216;

    localparam logic [1:0] OPC_CREDIT = 2'd0;
    localparam logic [1:0] OPC_SPAWN  = 2'd1;
    localparam logic [1:0] OPC_TICK   = 2'd2;
    localparam logic [1:0] OPC_NOP    = 2'd3;

    localparam logic [1:0] CFG_LIMIT = 2'd0;
    localparam logic [1:0] CFG_LIFT  = 2'd1;
    localparam logic [1:0] CFG_LIFE  = 2'd2;

    localparam logic [39:0] ONE_Q      = 40'd65536;
    localparam logic [39:0] CREDIT_MAX = {40{1'b1}};

    localparam logic signed [51:0] S32_MAX = 52'sd2147483647;
    localparam logic signed [51:0] S32_MIN = -52'sd2147483648;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] color;
        logic [30:0] size;
        logic [18:0] angle;
        logic [1:0]  atlas;
        logic [30:0] life;
    } entry_t;

    typedef struct packed {
        logic [63:0]      rsq;
        logic [IDX_W-1:0] idx;
    } skey_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CREDIT, ST_SPAWN, ST_OUT_WAIT,
        ST_TK_INIT, ST_TK_LIFT, ST_TK_RD, ST_TK_LD, ST_TK_LIFE,
        ST_TK_MX, ST_TK_MY, ST_TK_MZ, ST_TK_PZ, ST_TK_QX, ST_TK_QY, ST_TK_QZ,
        ST_TK_WR, ST_TK_END,
        ST_SR_INIT, ST_SR_OUTER, ST_SR_HOLD, ST_SR_RD, ST_SR_CMP, ST_SR_PUT,
        ST_EM_EMPTY, ST_EM_RD, ST_EM_IDX, ST_EM_LD, ST_EM_WAIT
    } state_t;

    typedef enum logic [4:0] {
        CMD_ACCEPT, CMD_CREDIT, CMD_SPAWN, CMD_WAIT,
        CMD_TK_INIT, CMD_TK_LIFT, CMD_TK_RD, CMD_TK_LD, CMD_TK_LIFE,
        CMD_TK_MX, CMD_TK_MY, CMD_TK_MZ, CMD_TK_PZ, CMD_TK_QX, CMD_TK_QY, CMD_TK_QZ,
        CMD_TK_WR, CMD_TK_END,
        CMD_SR_INIT, CMD_SR_OUTER, CMD_SR_HOLD, CMD_SR_RD, CMD_SR_CMP, CMD_SR_PUT,
        CMD_EM_EMPTY, CMD_EM_RD, CMD_EM_IDX, CMD_EM_LD, CMD_EM_WAIT
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t op;
        logic    in_ready;
    } ctl_cmd_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] op;
        logic       i_done;
        logic       dead;
        logic       sort_done;
        logic       shift;
        logic       j_zero;
        logic       out_taken;
        logic       empty;
        logic       em_last;
    } status_t;

    function automatic logic [31:0] sat32(input logic signed [51:0] v);
        logic [31:0] r;
        if (v > S32_MAX) begin
            r = 32'h7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

// ----- rtl/particle_update_depth_sort.sv -----
// Particle table with spawn credit, fixed-step motion and far-to-near depth sort (top level).
// One item is in work at a time; s_tready is high only while the block is idle. A spawn item
// waits for its result to be taken before the next item is accepted. A tick walks the table
// through one shared 33x33 multiplier, where a dead particle skips the motion and distance
// steps. It then runs an insertion sort over the key memory and emits the results one at a
// time, since each result needs a key read and a bank read and is copied into the other bank
// in sorted order. The single read port of the key memory and the one multiplier set the
// pace of a tick.
module particle_update_depth_sort (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // amount, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, color, size, angle, atlas_index
    input  logic [pud_pkg::IN_W-1:0]   s_tdata,
    // operation
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // admitted, draw_x, draw_y, draw_z, draw_size, draw_color, draw_atlas, draw_angle, draw_life
    output logic [pud_pkg::OUT_W-1:0]  m_tdata,
    // entry_valid
    output logic                       m_tuser,
    output logic                       m_tlast
);
    import pud_pkg::*;

    ctl_cmd_t cmd;
    status_t  sts;

    pud_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    pud_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // a pending result and a new input never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // spawn and empty-tick results are single and final
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("non-particle result without last");

    // admitted only appears on spawn results
    a_admit_spawn: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> !m_tuser)
        else $error("admitted flag on a particle result");

endmodule

// ----- rtl/pud_ctrl.sv -----
// Sequencer for credit, spawn, tick update, insertion sort and emission.
module pud_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  pud_pkg::status_t  sts,
    output pud_pkg::ctl_cmd_t cmd
);
    import pud_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (sts.accepted) begin
                    case (sts.op)
                        OPC_CREDIT: state_next = ST_CREDIT;
                        OPC_SPAWN:  state_next = ST_SPAWN;
                        OPC_TICK:   state_next = ST_TK_INIT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CREDIT:   state_next = ST_IDLE;
            ST_SPAWN:    state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: if (sts.out_taken) state_next = ST_IDLE;
            ST_TK_INIT:  state_next = ST_TK_LIFT;
            ST_TK_LIFT:  state_next = ST_TK_RD;
            ST_TK_RD:    state_next = sts.i_done ? ST_TK_END : ST_TK_LD;
            ST_TK_LD:    state_next = ST_TK_LIFE;
            ST_TK_LIFE:  state_next = sts.dead ? ST_TK_RD : ST_TK_MX;
            ST_TK_MX:    state_next = ST_TK_MY;
            ST_TK_MY:    state_next = ST_TK_MZ;
            ST_TK_MZ:    state_next = ST_TK_PZ;
            ST_TK_PZ:    state_next = ST_TK_QX;
            ST_TK_QX:    state_next = ST_TK_QY;
            ST_TK_QY:    state_next = ST_TK_QZ;
            ST_TK_QZ:    state_next = ST_TK_WR;
            ST_TK_WR:    state_next = ST_TK_RD;
            ST_TK_END:   state_next = ST_SR_INIT;
            ST_SR_INIT:  state_next = ST_SR_OUTER;
            ST_SR_OUTER: begin
                if (!sts.sort_done) begin
                    state_next = ST_SR_HOLD;
                end else if (sts.empty) begin
                    state_next = ST_EM_EMPTY;
                end else begin
                    state_next = ST_EM_RD;
                end
            end
            ST_SR_HOLD:  state_next = ST_SR_RD;
            ST_SR_RD:    state_next = sts.j_zero ? ST_SR_PUT : ST_SR_CMP;
            ST_SR_CMP:   state_next = sts.shift ? ST_SR_RD : ST_SR_PUT;
            ST_SR_PUT:   state_next = ST_SR_OUTER;
            ST_EM_EMPTY: state_next = ST_OUT_WAIT;
            ST_EM_RD:    state_next = ST_EM_IDX;
            ST_EM_IDX:   state_next = ST_EM_LD;
            ST_EM_LD:    state_next = ST_EM_WAIT;
            ST_EM_WAIT: begin
                if (sts.out_taken) begin
                    state_next = sts.em_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.in_ready = 1'b0;
        cmd.op       = CMD_WAIT;
        case (state_reg)
            ST_IDLE: begin
                cmd.op       = CMD_ACCEPT;
                cmd.in_ready = 1'b1;
            end
            ST_CREDIT:   cmd.op = CMD_CREDIT;
            ST_SPAWN:    cmd.op = CMD_SPAWN;
            ST_OUT_WAIT: cmd.op = CMD_WAIT;
            ST_TK_INIT:  cmd.op = CMD_TK_INIT;
            ST_TK_LIFT:  cmd.op = CMD_TK_LIFT;
            ST_TK_RD:    cmd.op = CMD_TK_RD;
            ST_TK_LD:    cmd.op = CMD_TK_LD;
            ST_TK_LIFE:  cmd.op = CMD_TK_LIFE;
            ST_TK_MX:    cmd.op = CMD_TK_MX;
            ST_TK_MY:    cmd.op = CMD_TK_MY;
            ST_TK_MZ:    cmd.op = CMD_TK_MZ;
            ST_TK_PZ:    cmd.op = CMD_TK_PZ;
            ST_TK_QX:    cmd.op = CMD_TK_QX;
            ST_TK_QY:    cmd.op = CMD_TK_QY;
            ST_TK_QZ:    cmd.op = CMD_TK_QZ;
            ST_TK_WR:    cmd.op = CMD_TK_WR;
            ST_TK_END:   cmd.op = CMD_TK_END;
            ST_SR_INIT:  cmd.op = CMD_SR_INIT;
            ST_SR_OUTER: cmd.op = CMD_SR_OUTER;
            ST_SR_HOLD:  cmd.op = CMD_SR_HOLD;
            ST_SR_RD:    cmd.op = CMD_SR_RD;
            ST_SR_CMP:   cmd.op = CMD_SR_CMP;
            ST_SR_PUT:   cmd.op = CMD_SR_PUT;
            ST_EM_EMPTY: cmd.op = CMD_EM_EMPTY;
            ST_EM_RD:    cmd.op = CMD_EM_RD;
            ST_EM_IDX:   cmd.op = CMD_EM_IDX;
            ST_EM_LD:    cmd.op = CMD_EM_LD;
            ST_EM_WAIT:  cmd.op = CMD_EM_WAIT;
            default:     cmd.op = CMD_WAIT;
        endcase
    end

endmodule

// ----- rtl/pud_dp.sv -----
// Datapath: particle banks, sort key memory, shared multiplier, output register.
module pud_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [pud_pkg::IN_W-1:0]   s_tdata,
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pud_pkg::OUT_W-1:0]  m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast,
    input  pud_pkg::ctl_cmd_t          cmd,
    output pud_pkg::status_t           sts
);
    import pud_pkg::*;

    // configuration and persistent state
    logic [6:0]       limit_reg;
    logic [31:0]      lift_reg;
    logic [30:0]      life0_reg;
    logic [39:0]      credit_reg;
    logic [CNT_W-1:0] count_reg;
    logic             bank_reg;

    // working registers
    logic [IN_W-1:0]  in_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] j_reg;
    entry_t           ent_reg;
    skey_t            hold_reg;
    logic [63:0]      dist_reg;
    logic [47:0]      liftstep_reg;
    logic signed [65:0] prod_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_user_reg;
    logic             out_last_reg;

    // memories
    entry_t bank0_mem [CAPACITY];
    entry_t bank1_mem [CAPACITY];
    skey_t  sort_mem  [CAPACITY];
    entry_t bank0_q, bank1_q, cur_q;
    skey_t  sort_q;

    // input item fields
    logic [30:0] in_amount;
    logic [31:0] in_px, in_py, in_pz, in_vx, in_vy, in_vz, in_color;
    logic [30:0] in_size;
    logic [18:0] in_angle;
    logic [1:0]  in_atlas;

    assign in_amount = in_reg[30:0];
    assign in_px     = in_reg[62:31];
    assign in_py     = in_reg[94:63];
    assign in_pz     = in_reg[126:95];
    assign in_vx     = in_reg[158:127];
    assign in_vy     = in_reg[190:159];
    assign in_vz     = in_reg[222:191];
    assign in_color  = in_reg[254:223];
    assign in_size   = in_reg[285:255];
    assign in_angle  = in_reg[304:286];
    assign in_atlas  = in_reg[306:305];

    entry_t spawn_ent;
    always_comb begin
        spawn_ent.pos_x = in_px;
        spawn_ent.pos_y = in_py;
        spawn_ent.pos_z = in_pz;
        spawn_ent.vel_x = in_vx;
        spawn_ent.vel_y = in_vy;
        spawn_ent.vel_z = in_vz;
        spawn_ent.color = in_color;
        spawn_ent.size  = in_size;
        spawn_ent.angle = in_angle;
        spawn_ent.atlas = in_atlas;
        spawn_ent.life  = life0_reg;
    end

    // admission check
    logic [CMP_W-1:0] lim_ext, cap_ext, cnt_ext, lim_eff;
    assign lim_ext = CMP_W'(limit_reg);
    assign cap_ext = CMP_W'(CAPACITY);
    assign cnt_ext = CMP_W'(count_reg);
    assign lim_eff = (lim_ext > cap_ext) ? cap_ext : lim_ext;

    logic admit;
    assign admit = (credit_reg > ONE_Q) && (cnt_ext < lim_eff);

    logic [40:0] credit_sum;
    assign credit_sum = {1'b0, credit_reg} + {10'd0, in_amount};

    // life and motion arithmetic
    logic [31:0] life_diff;
    logic        dead;
    assign life_diff = {1'b0, ent_reg.life} - {1'b0, in_amount};
    assign dead      = life_diff[31] || (life_diff == 32'd0);

    logic signed [49:0] stp;      // floored Q16.16 product
    logic signed [51:0] stp_ext;
    assign stp     = prod_reg[65:16];
    assign stp_ext = {{2{stp[49]}}, stp};

    logic signed [51:0] vy_sum, px_sum, py_sum, pz_sum;
    assign vy_sum = {{20{ent_reg.vel_y[31]}}, ent_reg.vel_y}
                  + {{4{liftstep_reg[47]}}, liftstep_reg};
    assign px_sum = {{20{ent_reg.pos_x[31]}}, ent_reg.pos_x} + stp_ext;
    assign py_sum = {{20{ent_reg.pos_y[31]}}, ent_reg.pos_y} + stp_ext;
    assign pz_sum = {{20{ent_reg.pos_z[31]}}, ent_reg.pos_z} + stp_ext;

    // |camera - position| always fits in 32 bits
    logic [32:0] dx, dy, dz, ax, ay, az;
    assign dx = {in_px[31], in_px} - {ent_reg.pos_x[31], ent_reg.pos_x};
    assign dy = {in_py[31], in_py} - {ent_reg.pos_y[31], ent_reg.pos_y};
    assign dz = {in_pz[31], in_pz} - {ent_reg.pos_z[31], ent_reg.pos_z};
    assign ax = dx[32] ? (33'd0 - dx) : dx;
    assign ay = dy[32] ? (33'd0 - dy) : dy;
    assign az = dz[32] ? (33'd0 - dz) : dz;

    logic signed [32:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            CMD_TK_INIT: begin
                mul_a = {lift_reg[31], lift_reg};
                mul_b = {2'b00, in_amount};
            end
            CMD_TK_MX: begin
                mul_a = {ent_reg.vel_x[31], ent_reg.vel_x};
                mul_b = {2'b00, in_amount};
            end
            CMD_TK_MY: begin
                mul_a = {ent_reg.vel_y[31], ent_reg.vel_y};
                mul_b = {2'b00, in_amount};
            end
            CMD_TK_MZ: begin
                mul_a = {ent_reg.vel_z[31], ent_reg.vel_z};
                mul_b = {2'b00, in_amount};
            end
            CMD_TK_PZ: begin
                mul_a = ax;
                mul_b = ax;
            end
            CMD_TK_QX: begin
                mul_a = ay;
                mul_b = ay;
            end
            CMD_TK_QY: begin
                mul_a = az;
                mul_b = az;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // bank access: "cur" holds the table in logical order, "oth" receives the sorted copy
    logic             wr_cur_en, wr_oth_en;
    logic [IDX_W-1:0] wr_cur_addr, wr_oth_addr, bank_raddr;
    entry_t           wr_cur_data;

    assign wr_cur_en   = ((cmd.op == CMD_SPAWN) && admit) || (cmd.op == CMD_TK_WR);
    assign wr_cur_addr = (cmd.op == CMD_SPAWN) ? count_reg[IDX_W-1:0] : n_reg[IDX_W-1:0];
    assign wr_cur_data = (cmd.op == CMD_SPAWN) ? spawn_ent : ent_reg;
    assign wr_oth_en   = (cmd.op == CMD_EM_LD);
    assign wr_oth_addr = i_reg[IDX_W-1:0];
    assign bank_raddr  = (cmd.op == CMD_EM_IDX) ? sort_q.idx : i_reg[IDX_W-1:0];
    assign cur_q       = bank_reg ? bank1_q : bank0_q;

    logic             b0_we, b1_we;
    logic [IDX_W-1:0] b0_waddr, b1_waddr;
    entry_t           b0_wdata, b1_wdata;

    assign b0_we    = bank_reg ? wr_oth_en   : wr_cur_en;
    assign b0_waddr = bank_reg ? wr_oth_addr : wr_cur_addr;
    assign b0_wdata = bank_reg ? cur_q       : wr_cur_data;
    assign b1_we    = bank_reg ? wr_cur_en   : wr_oth_en;
    assign b1_waddr = bank_reg ? wr_cur_addr : wr_oth_addr;
    assign b1_wdata = bank_reg ? wr_cur_data : cur_q;

    always_ff @(posedge aclk) begin
        if (b0_we) begin
            bank0_mem[b0_waddr] <= b0_wdata;
        end
        bank0_q <= bank0_mem[bank_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b1_we) begin
            bank1_mem[b1_waddr] <= b1_wdata;
        end
        bank1_q <= bank1_mem[bank_raddr];
    end

    // sort key memory: {squared distance, slot in cur bank}
    logic             sort_we;
    logic [IDX_W-1:0] sort_waddr, sort_raddr;
    skey_t            sort_wdata;

    always_comb begin
        sort_we    = 1'b0;
        sort_waddr = j_reg;
        sort_wdata = hold_reg;
        case (cmd.op)
            CMD_TK_WR: begin
                sort_we        = 1'b1;
                sort_waddr     = n_reg[IDX_W-1:0];
                sort_wdata.rsq = dist_reg;
                sort_wdata.idx = n_reg[IDX_W-1:0];
            end
            CMD_SR_CMP: begin
                sort_we    = sort_q.rsq < hold_reg.rsq;
                sort_wdata = sort_q;
            end
            CMD_SR_PUT: begin
                sort_we = 1'b1;
            end
            default: begin
                sort_we = 1'b0;
            end
        endcase
    end

    assign sort_raddr = (cmd.op == CMD_SR_RD) ? (j_reg - 1'b1) : i_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (sort_we) begin
            sort_mem[sort_waddr] <= sort_wdata;
        end
        sort_q <= sort_mem[sort_raddr];
    end

    // status
    logic accepted, taken, em_last;
    assign accepted = s_tvalid && s_tready;
    assign taken    = out_valid_reg && m_tready;
    assign em_last  = ({1'b0, i_reg} + 1'b1) == {1'b0, count_reg};

    always_comb begin
        sts.accepted  = accepted;
        sts.op        = s_tuser;
        sts.i_done    = (i_reg == count_reg);
        sts.dead      = dead;
        sts.sort_done = (i_reg >= count_reg);
        sts.shift     = sort_q.rsq < hold_reg.rsq;
        sts.j_zero    = (j_reg == '0);
        sts.out_taken = taken;
        sts.empty     = (count_reg == '0);
        sts.em_last   = em_last;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 7'd64;
            lift_reg  <= 32'd1638;
            life0_reg <= 31'd39322;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LIMIT: limit_reg <= cfg_data[6:0];
                CFG_LIFT:  lift_reg  <= cfg_data;
                CFG_LIFE:  life0_reg <= cfg_data[30:0];
                default:   limit_reg <= limit_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
            count_reg  <= '0;
            bank_reg   <= 1'b0;
            i_reg      <= '0;
            n_reg      <= '0;
            j_reg      <= '0;
        end else begin
            case (cmd.op)
                CMD_CREDIT: begin
                    credit_reg <= credit_sum[40] ? CREDIT_MAX : credit_sum[39:0];
                end
                CMD_SPAWN: begin
                    if (admit) begin
                        count_reg  <= count_reg + 1'b1;
                        credit_reg <= credit_reg - ONE_Q;
                    end
                end
                CMD_TK_INIT: begin
                    i_reg <= '0;
                    n_reg <= '0;
                end
                CMD_TK_LIFE: begin
                    if (dead) begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                CMD_TK_WR: begin
                    i_reg <= i_reg + 1'b1;
                    n_reg <= n_reg + 1'b1;
                end
                CMD_TK_END: count_reg <= n_reg;
                CMD_SR_INIT: i_reg <= CNT_W'(1);
                CMD_SR_OUTER: begin
                    if (i_reg >= count_reg) begin
                        i_reg <= '0;
                    end
                end
                CMD_SR_HOLD: j_reg <= i_reg[IDX_W-1:0];
                CMD_SR_CMP: begin
                    if (sort_q.rsq < hold_reg.rsq) begin
                        j_reg <= j_reg - 1'b1;
                    end
                end
                CMD_SR_PUT: i_reg <= i_reg + 1'b1;
                CMD_EM_WAIT: begin
                    if (taken) begin
                        i_reg <= i_reg + 1'b1;
                        if (em_last) begin
                            bank_reg <= ~bank_reg;
                        end
                    end
                end
                default: i_reg <= i_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            CMD_ACCEPT: begin
                if (accepted) begin
                    in_reg <= s_tdata;
                end
            end
            CMD_TK_LIFT: liftstep_reg <= stp[47:0];
            CMD_TK_LD:   ent_reg <= cur_q;
            CMD_TK_LIFE: begin
                ent_reg.life  <= life_diff[30:0];
                ent_reg.vel_y <= sat32(vy_sum);
            end
            CMD_TK_MY:   ent_reg.pos_x <= sat32(px_sum);
            CMD_TK_MZ:   ent_reg.pos_y <= sat32(py_sum);
            CMD_TK_PZ:   ent_reg.pos_z <= sat32(pz_sum);
            CMD_TK_QX:   dist_reg <= prod_reg[63:0];
            CMD_TK_QY:   dist_reg <= add_sat64(dist_reg, prod_reg[63:0]);
            CMD_TK_QZ:   dist_reg <= add_sat64(dist_reg, prod_reg[63:0]);
            CMD_SR_HOLD: hold_reg <= sort_q;
            default:     dist_reg <= dist_reg;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == CMD_SPAWN || cmd.op == CMD_EM_EMPTY || cmd.op == CMD_EM_LD) begin
            out_valid_reg <= 1'b1;
        end else if (taken) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            CMD_SPAWN: begin
                out_data_reg <= {{(OUT_W-1){1'b0}}, admit};
                out_user_reg <= 1'b0;
                out_last_reg <= 1'b1;
            end
            CMD_EM_EMPTY: begin
                out_data_reg <= '0;
                out_user_reg <= 1'b0;
                out_last_reg <= 1'b1;
            end
            CMD_EM_LD: begin
                out_data_reg <= {4'd0, cur_q.life, cur_q.angle, cur_q.atlas, cur_q.color,
                                 cur_q.size, cur_q.pos_z, cur_q.pos_y, cur_q.pos_x, 1'b0};
                out_user_reg <= 1'b1;
                out_last_reg <= em_last;
            end
            default: out_last_reg <= out_last_reg;
        endcase
    end

    assign s_tready = cmd.in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
